FILE: hw/rtl/fdr_pkg.sv
// Shared types and constants for the dielectric Fresnel reflectance pipeline.
// No dependencies.
`default_nettype none
package fdr_pkg;

  localparam int unsigned SQRT_STEPS = 15;  // root bits of a Q1.14 value
  localparam int unsigned SINT_STEPS = 14;  // quotient bits of sin_t
  localparam int unsigned COEF_STEPS = 17;  // quotient bits of a Q1.16 coefficient

  localparam logic [16:0] Q14_ONE = 17'd16384;
  localparam logic [28:0] Q28_ONE = 29'd268435456;
  localparam logic [16:0] Q16_ONE = 17'd65536;

  localparam logic [15:0] INDEX_INCIDENT_RESET    = 16'd4096;
  localparam logic [15:0] INDEX_TRANSMITTED_RESET = 16'd6144;

  // Register decode on paddr[2]
  localparam logic REG_INDEX_INCIDENT    = 1'b0;
  localparam logic REG_INDEX_TRANSMITTED = 1'b1;

  // Values that travel with an item down the whole pipeline
  typedef struct packed {
    logic [15:0] ni;
    logic [15:0] nt;
    logic [14:0] c;
    logic        tir;
  } side_t;

  // Bit-pair square root step state
  typedef struct packed {
    logic [16:0] rem;
    logic [14:0] root;
    logic [29:0] val;
  } sqrt_t;

  // Restoring division step state
  typedef struct packed {
    logic [31:0] rem;
    logic [16:0] low;
    logic [16:0] quo;
    logic [31:0] dvs;
  } div_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fdr_sqrt_cell.sv
// One cell of the square root chain: resolves one root bit per cycle while en is high.
// Depends on fdr_pkg.
`default_nettype none
module fdr_sqrt_cell import fdr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  valid_i,
  input  wire side_t side_i,
  input  wire sqrt_t data_i,
  output logic       valid_o,
  output side_t      side_o,
  output sqrt_t      data_o
);

  logic [18:0] r;
  logic [16:0] trial;
  logic        ge;
  sqrt_t       data_next;

  // bring in the next bit pair and try a one bit
  always_comb begin
    r     = {data_i.rem, data_i.val[29:28]};
    trial = {data_i.root, 2'b01};
    ge    = (r >= {2'b00, trial});
    data_next.rem  = ge ? 17'(r - {2'b00, trial}) : r[16:0];
    data_next.root = {data_i.root[13:0], ge};
    data_next.val  = {data_i.val[27:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      data_o <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_div_cell.sv
// One cell of a restoring divider chain: one quotient bit per cycle while en is high.
// Depends on fdr_pkg.
`default_nettype none
module fdr_div_cell import fdr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  en,
  input  wire logic  valid_i,
  input  wire side_t side_i,
  input  wire div_t  data_i,
  output logic       valid_o,
  output side_t      side_o,
  output div_t       data_o
);

  logic [32:0] r;
  logic        ge;
  div_t        data_next;

  // shift in one dividend bit, subtract when it fits
  always_comb begin
    r  = {data_i.rem, data_i.low[16]};
    ge = (r >= {1'b0, data_i.dvs});
    data_next.rem = ge ? 32'(r - {1'b0, data_i.dvs}) : r[31:0];
    data_next.low = {data_i.low[15:0], 1'b0};
    data_next.quo = {data_i.quo[15:0], ge};
    data_next.dvs = data_i.dvs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      data_o <= data_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fresnel_dielectric_reflectance.sv
// Top level of the dielectric Fresnel reflectance pipeline.
// Depends on fdr_pkg, fdr_sqrt_cell, fdr_div_cell.
//
// Usage:
//   Input channel in_valid/in_stall carries one item: cos_incident (Q1.14).
//   Output channel out_valid/out_stall returns one item per input:
//   reflectance (Q1.16) and total_internal.
//   The two indices (Q4.12) are written over the APB port at 0x0 and 0x4;
//   a zero index is taken as the smallest nonzero code.
//   Throughput is one item per cycle unless the output stalls: the
//   datapath is a chain of cells, two square root chains of 15 cells,
//   a 14-cell divider for sin_t and two 17-cell dividers for the
//   coefficients, each cell settling one result bit.
//   When out_valid is high and out_stall is high the whole pipeline holds
//   and in_stall rises in the same cycle; no item is dropped.
//   Reset clears all valid bits and loads the indices with 1.0 and 1.5.
`default_nettype none
module fresnel_dielectric_reflectance import fdr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] cos_incident,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      reflectance,
  output logic             total_internal,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        en;
  logic [15:0] index_incident;
  logic [15:0] index_transmitted;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign pready   = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      index_incident    <= INDEX_INCIDENT_RESET;
      index_transmitted <= INDEX_TRANSMITTED_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_INDEX_INCIDENT:    index_incident    <= pwdata[15:0];
        REG_INDEX_TRANSMITTED: index_transmitted <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INDEX_INCIDENT:    prdata = {16'd0, index_incident};
      REG_INDEX_TRANSMITTED: prdata = {16'd0, index_transmitted};
      default:               prdata = '0;
    endcase
  end

  // stage 0: clamp, direction and index swap
  logic signed [15:0] cosv;
  logic               leaving;
  logic [15:0]        ni_eff, nt_eff;
  side_t              s0_side_next;
  logic               s0_valid;
  side_t              s0_side;

  always_comb begin
    cosv = cos_incident;
    if (cosv > 16'sd16384) cosv = 16'sd16384;
    if (cosv < -16'sd16384) cosv = -16'sd16384;
    leaving = (cosv <= 16'sd0);
    ni_eff  = (index_incident == 16'd0) ? 16'd1 : index_incident;
    nt_eff  = (index_transmitted == 16'd0) ? 16'd1 : index_transmitted;
    s0_side_next.ni  = leaving ? nt_eff : ni_eff;
    s0_side_next.nt  = leaving ? ni_eff : nt_eff;
    s0_side_next.c   = leaving ? 15'(-cosv) : cosv[14:0];
    s0_side_next.tir = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_side <= s0_side_next;
    end
  end

  // stage 1: 1 - cos^2
  logic [29:0] c_sq;
  logic        s1_valid;
  side_t       s1_side;
  sqrt_t       s1_data;

  assign c_sq = s0_side.c * s0_side.c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side       <= s0_side;
      s1_data.rem   <= '0;
      s1_data.root  <= '0;
      s1_data.val   <= {1'b0, 29'(Q28_ONE - c_sq[28:0])};
    end
  end

  // sin_i square root chain
  logic  sa_valid [SQRT_STEPS+1];
  side_t sa_side  [SQRT_STEPS+1];
  sqrt_t sa_data  [SQRT_STEPS+1];

  assign sa_valid[0] = s1_valid;
  assign sa_side[0]  = s1_side;
  assign sa_data[0]  = s1_data;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_sin
    fdr_sqrt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(sa_valid[i]),
      .side_i (sa_side[i]),
      .data_i (sa_data[i]),
      .valid_o(sa_valid[i+1]),
      .side_o (sa_side[i+1]),
      .data_o (sa_data[i+1])
    );
  end

  // stage 3: n_i * sin_i, total internal reflection test
  logic [30:0] num;
  logic        tir_now;
  side_t       s3_side_next;
  logic        s3_valid;
  side_t       s3_side;
  div_t        s3_data;

  always_comb begin
    num          = sa_side[SQRT_STEPS].ni * sa_data[SQRT_STEPS].root;
    tir_now      = (num >= {1'b0, sa_side[SQRT_STEPS].nt, 14'd0});
    s3_side_next = sa_side[SQRT_STEPS];
    s3_side_next.tir = tir_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sa_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side     <= s3_side_next;
      s3_data.rem <= {15'd0, num[30:14]};
      s3_data.low <= {num[13:0], 3'd0};
      s3_data.quo <= '0;
      s3_data.dvs <= {16'd0, sa_side[SQRT_STEPS].nt};
    end
  end

  // sin_t divider chain
  logic  da_valid [SINT_STEPS+1];
  side_t da_side  [SINT_STEPS+1];
  div_t  da_data  [SINT_STEPS+1];

  assign da_valid[0] = s3_valid;
  assign da_side[0]  = s3_side;
  assign da_data[0]  = s3_data;

  for (genvar i = 0; i < SINT_STEPS; i++) begin : g_div_sin
    fdr_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(da_valid[i]),
      .side_i (da_side[i]),
      .data_i (da_data[i]),
      .valid_o(da_valid[i+1]),
      .side_o (da_side[i+1]),
      .data_o (da_data[i+1])
    );
  end

  // stage 5: 1 - sin_t^2
  logic [13:0] sin_t;
  logic [27:0] st_sq;
  logic        s5_valid;
  side_t       s5_side;
  sqrt_t       s5_data;

  assign sin_t = da_data[SINT_STEPS].quo[13:0];
  assign st_sq = sin_t * sin_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= da_valid[SINT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side      <= da_side[SINT_STEPS];
      s5_data.rem  <= '0;
      s5_data.root <= '0;
      s5_data.val  <= {1'b0, 29'(Q28_ONE - {1'b0, st_sq})};
    end
  end

  // cos_t square root chain
  logic  sb_valid [SQRT_STEPS+1];
  side_t sb_side  [SQRT_STEPS+1];
  sqrt_t sb_data  [SQRT_STEPS+1];

  assign sb_valid[0] = s5_valid;
  assign sb_side[0]  = s5_side;
  assign sb_data[0]  = s5_data;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt_cos
    fdr_sqrt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(sb_valid[i]),
      .side_i (sb_side[i]),
      .data_i (sb_data[i]),
      .valid_o(sb_valid[i+1]),
      .side_o (sb_side[i+1]),
      .data_o (sb_data[i+1])
    );
  end

  // stage 7: the four index products
  side_t       s7_side;
  logic        s7_valid;
  logic [30:0] p_par, q_par, p_perp, q_perp;
  side_t       sb_last;

  assign sb_last = sb_side[SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else if (en) begin
      s7_valid <= sb_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side <= sb_last;
      p_par   <= sb_last.nt * sb_last.c;
      q_par   <= sb_last.ni * sb_data[SQRT_STEPS].root;
      p_perp  <= sb_last.ni * sb_last.c;
      q_perp  <= sb_last.nt * sb_data[SQRT_STEPS].root;
    end
  end

  // stage 8: difference and sum, set up both coefficient dividers
  logic [31:0] diff_par, sum_par, diff_perp, sum_perp;
  logic [47:0] n_par, n_perp;
  logic        s8_valid;
  side_t       s8_side;
  div_t        s8_par, s8_perp;

  always_comb begin
    diff_par  = (p_par >= q_par) ? {1'b0, 31'(p_par - q_par)} : {1'b0, 31'(q_par - p_par)};
    sum_par   = {1'b0, p_par} + {1'b0, q_par};
    diff_perp = (p_perp >= q_perp) ? {1'b0, 31'(p_perp - q_perp)}
                                   : {1'b0, 31'(q_perp - p_perp)};
    sum_perp  = {1'b0, p_perp} + {1'b0, q_perp};
    n_par     = {diff_par, 16'd0} + {17'd0, sum_par[31:1]};
    n_perp    = {diff_perp, 16'd0} + {17'd0, sum_perp[31:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else if (en) begin
      s8_valid <= s7_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_side      <= s7_side;
      s8_par.rem   <= {1'b0, n_par[47:17]};
      s8_par.low   <= n_par[16:0];
      s8_par.quo   <= '0;
      s8_par.dvs   <= sum_par;
      s8_perp.rem  <= {1'b0, n_perp[47:17]};
      s8_perp.low  <= n_perp[16:0];
      s8_perp.quo  <= '0;
      s8_perp.dvs  <= sum_perp;
    end
  end

  // coefficient divider chains, parallel and perpendicular
  logic  dp_valid [COEF_STEPS+1];
  side_t dp_side  [COEF_STEPS+1];
  div_t  dp_data  [COEF_STEPS+1];
  logic  dq_valid [COEF_STEPS+1];
  side_t dq_side  [COEF_STEPS+1];
  div_t  dq_data  [COEF_STEPS+1];

  assign dp_valid[0] = s8_valid;
  assign dp_side[0]  = s8_side;
  assign dp_data[0]  = s8_par;
  assign dq_valid[0] = s8_valid;
  assign dq_side[0]  = s8_side;
  assign dq_data[0]  = s8_perp;

  for (genvar i = 0; i < COEF_STEPS; i++) begin : g_div_coef
    fdr_div_cell u_par (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(dp_valid[i]),
      .side_i (dp_side[i]),
      .data_i (dp_data[i]),
      .valid_o(dp_valid[i+1]),
      .side_o (dp_side[i+1]),
      .data_o (dp_data[i+1])
    );
    fdr_div_cell u_perp (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .valid_i(dq_valid[i]),
      .side_i (dq_side[i]),
      .data_i (dq_data[i]),
      .valid_o(dq_valid[i+1]),
      .side_o (dq_side[i+1]),
      .data_o (dq_data[i+1])
    );
  end

  // stage 10: squares of the coefficients
  logic        s10_valid;
  logic        s10_tir;
  logic [33:0] sq_par, sq_perp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (en) begin
      s10_valid <= dp_valid[COEF_STEPS] && dq_valid[COEF_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_tir <= dp_side[COEF_STEPS].tir | dq_side[COEF_STEPS].tir;
      sq_par  <= dp_data[COEF_STEPS].quo * dp_data[COEF_STEPS].quo;
      sq_perp <= dq_data[COEF_STEPS].quo * dq_data[COEF_STEPS].quo;
    end
  end

  // output register: mean of the squares, total internal reflection forces one
  logic [35:0] refl_sum;

  assign refl_sum = {2'b00, sq_par} + {2'b00, sq_perp} + {19'd0, Q16_ONE};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reflectance    <= s10_tir ? Q16_ONE : refl_sum[33:17];
      total_internal <= s10_tir;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fdr_checker.sv
// Port-level checks for the Fresnel reflectance block, bound to the top level.
// Depends on fresnel_dielectric_reflectance.
`default_nettype none
module fdr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [16:0] reflectance,
  input wire logic        total_internal
);

  // a waiting item stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reflectance))
    else $error("output item changed while stalled");

  // input is held off only by a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reflectance never exceeds one
  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reflectance <= 17'd65536)
    else $error("reflectance above one");

  // total internal reflection reports full reflectance
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_internal |-> reflectance == 17'd65536)
    else $error("total internal reflection without full reflectance");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .reflectance   (reflectance),
  .total_internal(total_internal)
);
`default_nettype wire
